FILE: hw/rtl/fcpq_pkg.sv
// Shared types and constants for the four-class priority queue.
`timescale 1ns / 1ps
package fcpq_pkg;

  localparam int ID_W   = 16;
  localparam int CLS_W  = 2;
  localparam int TIME_W = 10;
  localparam int BUD_W  = 16;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;

  localparam logic [BUD_W-1:0] BUDGET_RESET = 16'd360;

  // Command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RPT = 2'd2;

  // Request FIFO between front and back
  localparam int REQ_FIFO_DEPTH = 2;
  localparam int REQ_PTR_W      = 1;
  localparam int REQ_CNT_W      = 2;

  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_RPT = 2'd2
  } req_op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_NONE  = 2'd3
  } status_e;

  typedef enum logic {
    BK_IDLE   = 1'b0,
    BK_REPORT = 1'b1
  } bk_state_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [CLS_W-1:0]  cls;
    logic [TIME_W-1:0] tm;
  } entry_t;

  typedef struct packed {
    req_op_e op;
    entry_t  ent;
  } req_t;

endpackage

FILE: hw/rtl/fcpq_front.sv
// Front end: decodes input requests and buffers them in a short FIFO.
`timescale 1ns / 1ps
module fcpq_front import fcpq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [ID_W-1:0]   ticket_id_i,
  input  logic [CLS_W-1:0]  member_class_i,
  input  logic [TIME_W-1:0] service_time_i,
  output logic              req_valid_o,
  output req_t              req_o,
  input  logic              req_pop_i
);

  req_t                 fifo_q [REQ_FIFO_DEPTH];
  logic [REQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [REQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [REQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                 accept;
  logic                 push;
  logic                 pop;
  req_t                 dec_req;
  logic                 dec_ok;

  assign in_stall_o = (cnt_q == REQ_CNT_W'(REQ_FIFO_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  // Unused command code is consumed and dropped here.
  always_comb begin
    dec_ok        = 1'b1;
    dec_req.op    = OP_ENQ;
    dec_req.ent.id  = ticket_id_i;
    dec_req.ent.cls = member_class_i;
    dec_req.ent.tm  = service_time_i;
    unique case (cmd_i)
      CMD_ENQ: dec_req.op = OP_ENQ;
      CMD_DEQ: dec_req.op = OP_DEQ;
      CMD_RPT: dec_req.op = OP_RPT;
      default: dec_ok = 1'b0;
    endcase
  end

  assign push        = accept && dec_ok;
  assign req_valid_o = (cnt_q != '0);
  assign pop         = req_pop_i && req_valid_o;
  assign req_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + REQ_CNT_W'(push) - REQ_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= dec_req;
    end
  end

endmodule

FILE: hw/rtl/fcpq_back.sv
// Back end: sorted entry store, command sequencer and output register.
`timescale 1ns / 1ps
module fcpq_back import fcpq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [BUD_W-1:0]  cfg_budget_i,
  input  logic              req_valid_i,
  input  req_t              req_i,
  output logic              req_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [STAT_W-1:0] status_o,
  output logic [ID_W-1:0]   out_ticket_id_o,
  output logic [CLS_W-1:0]  out_class_o,
  output logic [TIME_W-1:0] out_time_o,
  output logic              last_o
);

  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int SUM_W   = $clog2(QUEUE_DEPTH * ((1 << TIME_W) - 1) + 1);
  localparam int TOT_W   = (SUM_W > BUD_W) ? SUM_W : BUD_W;

  entry_t           ent_q [QUEUE_DEPTH];
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [TOT_W-1:0] total_q, total_d;
  logic [TOT_W-1:0] total_n;
  logic [BUD_W-1:0] budget_q;
  bk_state_e        state_q, state_d;

  logic [QUEUE_DEPTH-1:0] ins;
  logic [QUEUE_DEPTH-1:0] ins_prev;
  logic             do_enq, do_deq, do_rot;
  logic             full, empty, hit, final_step;
  logic             out_free;
  logic             emit;
  status_e          res_status;
  entry_t           res_ent;
  logic             res_last;

  logic             out_vld_q;
  logic [STAT_W-1:0] stat_q;
  entry_t           oent_q;
  logic             last_q;

  assign full     = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty    = (cnt_q == '0);
  assign out_free = !out_vld_q || !out_stall_i;

  // Running total for the report walk; the head is the current entry.
  assign total_n    = total_q + TOT_W'(ent_q[0].tm);
  assign hit        = total_n > TOT_W'(budget_q);
  assign final_step = (CNT_W'(idx_q) == cnt_q - CNT_W'(1));

  // Insert mask: slots at or past the insert point; monotone since store is sorted.
  assign ins_prev = {ins[QUEUE_DEPTH-2:0], 1'b0};

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_slot
    entry_t prv_e;
    entry_t nxt_e;

    assign ins[k] = (CNT_W'(k) < cnt_q) ? (ent_q[k].cls > req_i.ent.cls)
                                        : (CNT_W'(k) == cnt_q);

    if (k == 0) begin : g_first
      assign prv_e = req_i.ent;
    end else begin : g_mid
      assign prv_e = ent_q[k-1];
    end

    if (k == QUEUE_DEPTH - 1) begin : g_tail
      assign nxt_e = ent_q[k];
    end else begin : g_body
      assign nxt_e = ent_q[k+1];
    end

    // Enqueue shifts up behind the insert point, dequeue shifts down,
    // report rotates the occupied slots by one.
    always_ff @(posedge clk_i) begin
      if (do_enq && ins[k]) begin
        ent_q[k] <= ins_prev[k] ? prv_e : req_i.ent;
      end else if (do_deq) begin
        ent_q[k] <= nxt_e;
      end else if (do_rot && (CNT_W'(k) < cnt_q)) begin
        ent_q[k] <= (CNT_W'(k) == cnt_q - CNT_W'(1)) ? ent_q[0] : nxt_e;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    total_d    = total_q;
    req_pop_o  = 1'b0;
    do_enq     = 1'b0;
    do_deq     = 1'b0;
    do_rot     = 1'b0;
    emit       = 1'b0;
    res_status = STAT_OK;
    res_ent    = '0;
    res_last   = 1'b1;
    unique case (state_q)
      BK_IDLE: begin
        if (req_valid_i && out_free) begin
          req_pop_o = 1'b1;
          case (req_i.op)
            OP_ENQ: begin
              emit       = 1'b1;
              res_status = full ? STAT_FULL : STAT_OK;
              do_enq     = !full;
              cnt_d      = full ? cnt_q : cnt_q + CNT_W'(1);
            end
            OP_DEQ: begin
              emit = 1'b1;
              if (empty) begin
                res_status = STAT_EMPTY;
              end else begin
                res_ent = ent_q[0];
                do_deq  = 1'b1;
                cnt_d   = cnt_q - CNT_W'(1);
              end
            end
            OP_RPT: begin
              if (empty) begin
                emit       = 1'b1;
                res_status = STAT_NONE;
              end else begin
                state_d = BK_REPORT;
                idx_d   = '0;
                total_d = '0;
              end
            end
            default: ;
          endcase
        end
      end
      BK_REPORT: begin
        if (out_free) begin
          do_rot  = 1'b1;
          total_d = total_n;
          idx_d   = idx_q + IDX_W'(1);
          if (final_step) begin
            // Totals only grow: a miss on the last entry means no hits at all.
            emit       = 1'b1;
            state_d    = BK_IDLE;
            res_status = hit ? STAT_OK : STAT_NONE;
            res_ent    = hit ? ent_q[0] : '0;
          end else if (hit) begin
            emit     = 1'b1;
            res_ent  = ent_q[0];
            res_last = 1'b0;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      cnt_q     <= '0;
      idx_q     <= '0;
      total_q   <= '0;
      budget_q  <= BUDGET_RESET;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      total_q   <= total_d;
      if (cfg_we_i) begin
        budget_q <= cfg_budget_i;
      end
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      stat_q <= res_status;
      oent_q <= res_ent;
      last_q <= res_last;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign status_o        = stat_q;
  assign out_ticket_id_o = oent_q.id;
  assign out_class_o     = oent_q.cls;
  assign out_time_o      = oent_q.tm;
  assign last_o          = last_q;

endmodule

FILE: hw/rtl/four_class_priority_queue.sv
// Top level of the four-class priority queue.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request: cmd_i selects
//   enqueue, dequeue head or budget report; cmd 3 is swallowed with no result.
//   Output channel (out_valid_o / out_stall_i) returns results; last_o marks
//   the final result of each request. Enqueue and dequeue give one result,
//   report gives one per entry whose running service-time total exceeds the
//   budget, or a single status NONE result.
//   Config channel (cfg_valid_i / cfg_ready_o) writes time_budget; always ready.
//   Sequence: the front end buffers an accepted request in the request FIFO;
//   the back end then handles enqueue and dequeue in its idle state, while a
//   report moves it to the report state, which walks every stored entry in
//   turn, each rotation of the entry store bringing the next entry to the
//   head slot.
//   A two-deep request FIFO decouples the front from the back, so new
//   requests are taken while a report walks or a result waits.
//   Reset: queue empty, budget 360, no clearing pass needed.
//   Receiver stall: the result is held in the output register and the back
//   end pauses; the input stalls once the request FIFO fills.
module four_class_priority_queue import fcpq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [ID_W-1:0]   ticket_id_i,
  input  logic [CLS_W-1:0]  member_class_i,
  input  logic [TIME_W-1:0] service_time_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [STAT_W-1:0] status_o,
  output logic [ID_W-1:0]   out_ticket_id_o,
  output logic [CLS_W-1:0]  out_class_o,
  output logic [TIME_W-1:0] out_time_o,
  output logic              last_o,
  // budget register write
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [BUD_W-1:0]  cfg_time_budget_i
);

  logic req_valid;
  req_t req;
  logic req_pop;

  assign cfg_ready_o = 1'b1;

  // Front: decode and queue requests
  fcpq_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .ticket_id_i    (ticket_id_i),
    .member_class_i (member_class_i),
    .service_time_i (service_time_i),
    .req_valid_o    (req_valid),
    .req_o          (req),
    .req_pop_i      (req_pop)
  );

  // Back: entry store, sequencer, result register
  fcpq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_budget_i    (cfg_time_budget_i),
    .req_valid_i     (req_valid),
    .req_i           (req),
    .req_pop_o       (req_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .out_ticket_id_o (out_ticket_id_o),
    .out_class_o     (out_class_o),
    .out_time_o      (out_time_o),
    .last_o          (last_o)
  );

endmodule

FILE: dv/four_class_priority_queue_tb.sv
// Self-checking testbench for the four-class priority queue.
`timescale 1ns / 1ps
module four_class_priority_queue_tb;
  import fcpq_pkg::*;

  localparam int QDEPTH = 16;
  // cmd 3 has no meaning in the block; it must be swallowed silently
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  // cycles to let the back end settle once nothing is owed (covers a
  // swallowed request still sitting in the two-deep request FIFO)
  localparam int SETTLE_CYCLES = 8;
  localparam int RX_HOLD_CYCLES = 80;

  // One result as the block should return it
  typedef struct {
    status_e           status;
    logic [ID_W-1:0]   id;
    logic [CLS_W-1:0]  cls;
    logic [TIME_W-1:0] tm;
    logic              is_last;
  } queue_result_t;

  // Keeps its own copy of the ticket store and budget, turns every accepted
  // request into the results it owes, and checks returned results in order.
  class ticket_queue_checker;
    int unsigned capacity;
    logic [BUD_W-1:0] budget;
    entry_t tickets[$];            // head first
    queue_result_t owed_results[$];
    int unsigned errors = 0;
    int unsigned results_seen = 0;
    int unsigned cmd_count[4] = '{0, 0, 0, 0};
    int unsigned full_rejects = 0;
    int unsigned empty_dequeues = 0;
    int unsigned longest_report = 0;

    function new(int unsigned depth);
      capacity = depth;
      budget = BUDGET_RESET;
    endfunction

    function void owe(status_e st, entry_t e, logic is_last);
      queue_result_t r;
      r.status = st;
      r.id = e.id;
      r.cls = e.cls;
      r.tm = e.tm;
      r.is_last = is_last;
      owed_results.push_back(r);
    endfunction

    function void take_request(logic [CMD_W-1:0] cmd, entry_t e);
      int unsigned pos;
      int unsigned total;
      int unsigned hits;
      entry_t head;
      cmd_count[cmd]++;
      case (cmd)
        CMD_ENQ: begin
          if (tickets.size() >= capacity) begin
            full_rejects++;
            owe(STAT_FULL, '0, 1'b1);
          end else begin
            // stable insert: behind every entry of equal or better class
            pos = 0;
            while (pos < tickets.size() && tickets[pos].cls <= e.cls) pos++;
            tickets.insert(pos, e);
            owe(STAT_OK, '0, 1'b1);
          end
        end
        CMD_DEQ: begin
          if (tickets.size() == 0) begin
            empty_dequeues++;
            owe(STAT_EMPTY, '0, 1'b1);
          end else begin
            head = tickets.pop_front();
            owe(STAT_OK, head, 1'b1);
          end
        end
        CMD_RPT: begin
          total = 0;
          hits = 0;
          foreach (tickets[i]) begin
            total += tickets[i].tm;
            if (total > budget) begin
              owe(STAT_OK, tickets[i], 1'b0);
              hits++;
            end
          end
          if (hits == 0) owe(STAT_NONE, '0, 1'b1);
          else owed_results[owed_results.size()-1].is_last = 1'b1;
          if (hits > longest_report) longest_report = hits;
        end
        default: ;
      endcase
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $error("%s: expected %0d, got %0d", field, want, got);
      end
    endfunction

    function void match_result(logic [STAT_W-1:0] st, logic [ID_W-1:0] id,
                               logic [CLS_W-1:0] cls, logic [TIME_W-1:0] tm,
                               logic is_last);
      queue_result_t want;
      if (owed_results.size() == 0) begin
        errors++;
        $error("result with nothing owed: status %0d id %0d", st, id);
        return;
      end
      want = owed_results.pop_front();
      results_seen++;
      compare("status", want.status, st);
      compare("out_ticket_id", want.id, id);
      compare("out_class", want.cls, cls);
      compare("out_time", want.tm, tm);
      compare("last", want.is_last, is_last);
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [CMD_W-1:0]  cmd_i = '0;
  logic [ID_W-1:0]   ticket_id_i = '0;
  logic [CLS_W-1:0]  member_class_i = '0;
  logic [TIME_W-1:0] service_time_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [STAT_W-1:0] status_o;
  logic [ID_W-1:0]   out_ticket_id_o;
  logic [CLS_W-1:0]  out_class_o;
  logic [TIME_W-1:0] out_time_o;
  logic              last_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [BUD_W-1:0]  cfg_time_budget_i = '0;

  ticket_queue_checker checker_h;
  int unsigned tx_idle_pct = 27;   // sender gap odds, percent per cycle
  int unsigned rx_stall_pct = 27;  // receiver stall odds, percent per cycle
  int unsigned hold_left = 0;      // receiver long hold, counted down below
  int unsigned budget_writes = 0;

  four_class_priority_queue #(
    .QUEUE_DEPTH(QDEPTH)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .ticket_id_i      (ticket_id_i),
    .member_class_i   (member_class_i),
    .service_time_i   (service_time_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .out_ticket_id_o  (out_ticket_id_o),
    .out_class_o      (out_class_o),
    .out_time_o       (out_time_o),
    .last_o           (last_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_time_budget_i(cfg_time_budget_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Receiver: random stalls, or a solid hold while hold_left runs down.
  // Driven on the falling edge so the block sees a stable stall at the rise.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i = 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i = ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Result monitor: a result moves on a rise with valid high and no stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0)
      checker_h.match_result(status_o, out_ticket_id_o, out_class_o,
                             out_time_o, last_o);
  end

  // Offer one request, with random gaps first; valid stays up and the
  // payload holds until the block takes it. Valid is lowered only by the
  // next call (as a gap) or by drain().
  task automatic send_request(input logic [CMD_W-1:0] cmd,
                              input logic [ID_W-1:0] id,
                              input logic [CLS_W-1:0] cls,
                              input logic [TIME_W-1:0] tm);
    entry_t e;
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    cmd_i = cmd;
    ticket_id_i = id;
    member_class_i = cls;
    service_time_i = tm;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    e.id = id;
    e.cls = cls;
    e.tm = tm;
    checker_h.take_request(cmd, e);
  endtask

  // Random request; the rest above enq_pct + deq_pct is mostly reports
  // with a few unused commands.
  task automatic random_request(input int unsigned enq_pct,
                                input int unsigned deq_pct);
    int unsigned pick;
    logic [CMD_W-1:0] cmd;
    logic [TIME_W-1:0] tm;
    pick = $urandom_range(99);
    if (pick < enq_pct) cmd = CMD_ENQ;
    else if (pick < enq_pct + deq_pct) cmd = CMD_DEQ;
    else if (pick < 96) cmd = CMD_RPT;
    else cmd = CMD_NOP;
    // short service times now and then so that reports also come up empty
    tm = ($urandom_range(3) == 0) ? TIME_W'($urandom_range(63))
                                  : TIME_W'($urandom_range(1023));
    send_request(cmd, ID_W'($urandom()), CLS_W'($urandom_range(3)), tm);
  endtask

  // Sender stops until every owed result is back, then lets the back end
  // settle so a budget write lands on an idle block.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (checker_h.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_budget(input logic [BUD_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_time_budget_i = value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    checker_h.budget = value;
    budget_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    logic [BUD_W-1:0] phase_budget[5];
    checker_h = new(QDEPTH);
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty dequeue, empty report, unused command, field
    // extremes, FIFO order inside a class, a report past the reset budget.
    send_request(CMD_DEQ, '0, '0, '0);
    send_request(CMD_RPT, '0, '0, '0);
    send_request(CMD_NOP, '1, '1, '1);
    send_request(CMD_ENQ, 16'hffff, 2'd3, 10'd1023);
    send_request(CMD_ENQ, 16'h0000, 2'd0, 10'd0);
    send_request(CMD_ENQ, 16'h5a5a, 2'd1, 10'h200);
    send_request(CMD_ENQ, 16'ha5a5, 2'd2, 10'h1ff);
    send_request(CMD_ENQ, 16'h0001, 2'd0, 10'd300);
    send_request(CMD_RPT, '0, '0, '0);
    send_request(CMD_ENQ, 16'h1234, 2'd1, 10'd5);
    send_request(CMD_DEQ, '0, '0, '0);
    send_request(CMD_DEQ, '0, '0, '0);
    send_request(CMD_RPT, '0, '0, '0);
    drain();

    // Fill past capacity with no gaps and no stalls: full rejections
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    repeat (QDEPTH + 2) random_request(100, 0);
    send_request(CMD_RPT, '0, '0, '0);
    drain();

    // Zero budget on a full store: the longest reports
    write_budget('0);
    tx_idle_pct = 27;
    rx_stall_pct = 27;
    // receiver goes deaf for a while; sender keeps offering until the
    // request FIFO backs up and the input stalls
    hold_left = RX_HOLD_CYCLES;
    repeat (6) random_request(10, 20);
    repeat (QDEPTH + 2) random_request(0, 100);

    // Random phases over a spread of budgets, extremes included
    phase_budget[0] = '1;
    phase_budget[1] = BUD_W'($urandom_range(4000));
    phase_budget[2] = BUDGET_RESET;
    phase_budget[3] = BUD_W'($urandom_range(65535));
    phase_budget[4] = BUD_W'($urandom_range(2500));
    foreach (phase_budget[p]) begin
      drain();
      write_budget(phase_budget[p]);
      repeat (16) random_request((p % 2 == 0) ? 55 : 40, 20);
    end

    drain();
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);
    if (checker_h.pending() != 0) begin
      checker_h.errors += checker_h.pending();
      $error("%0d results never arrived", checker_h.pending());
    end

    $display("Requests: %0d enqueue, %0d dequeue, %0d report, %0d unused; %0d results checked",
             checker_h.cmd_count[CMD_ENQ], checker_h.cmd_count[CMD_DEQ],
             checker_h.cmd_count[CMD_RPT], checker_h.cmd_count[CMD_NOP],
             checker_h.results_seen);
    $display("Full rejects %0d, empty dequeues %0d, longest report %0d, budget writes %0d",
             checker_h.full_rejects, checker_h.empty_dequeues,
             checker_h.longest_report, budget_writes);
    if (checker_h.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/fcpq_pkg.sv
hw/rtl/fcpq_front.sv
hw/rtl/fcpq_back.sv
hw/rtl/four_class_priority_queue.sv
dv/four_class_priority_queue_tb.sv
